### design/sobel_pkg.sv
// Shared types and constants for the Sobel edge threshold block.
`default_nettype none
package sobel_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int PIX_W         = 8;
	localparam int OUT_COL_W     = 11;
	localparam int ROW_W         = 12;
	localparam int CFG_W         = 12;
	localparam int THR_W         = 11;
	localparam int SUM_W         = 10;
	localparam int GRAD_W        = 11;
	localparam int SQ_W          = 20;
	localparam int MAG_W         = 21;
	localparam int THR_SQ_W      = 22;
	localparam int IN_DATA_W     = 24;
	localparam int OUT_DATA_W    = 48;
	localparam int WIN_CELLS     = 2;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = 2;
	localparam int FIFO_CNT_W    = 3;

	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;
	localparam int THR_RESET     = 20;
	localparam int MIN_DIM       = 3;

	localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;
	localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_EDGE_THRESH  = 2'd2
	} cfg_reg_t;

	// one column of the 3x3 window, top row first
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} win_col_t;

	typedef struct packed {
		logic                 last;
		logic [PIX_W-1:0]     blue;
		logic [PIX_W-1:0]     green;
		logic [PIX_W-1:0]     red;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
	} result_t;

endpackage
`default_nettype wire

### design/sobel_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sobel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### design/sobel_cell.sv
// One window column cell: holds three brightness values, shifts to its neighbor.
`default_nettype none
module sobel_cell
	import sobel_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     shift,
	input  wire win_col_t din,
	output win_col_t      dout
);

	win_col_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= din;
		end
	end

	assign dout = col_q;

endmodule
`default_nettype wire

### design/sobel_mag.sv
// Sobel gradients, squared magnitude and threshold compare, two register stages.
`default_nettype none
module sobel_mag
	import sobel_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                en,
	input  wire win_col_t            left,
	input  wire win_col_t            center,
	input  wire win_col_t            right,
	input  wire logic [THR_SQ_W-1:0] thr_sq,
	output logic                     is_edge
);

	logic        [SUM_W-1:0]    sum_l, sum_r, sum_t, sum_b;
	logic signed [GRAD_W-1:0]   gx, gy;
	logic signed [GRAD_W-1:0]   gx_s2, gy_s2;
	logic signed [2*GRAD_W-1:0] px, py;
	logic        [SQ_W-1:0]     sqx_s3, sqy_s3;
	logic        [MAG_W-1:0]    mag2;

	// weights 1,2,1 along each column / row
	always_comb begin
		sum_l = {2'b00, left.top}  + {1'b0, left.mid, 1'b0}  + {2'b00, left.bot};
		sum_r = {2'b00, right.top} + {1'b0, right.mid, 1'b0} + {2'b00, right.bot};
		sum_t = {2'b00, left.top}  + {1'b0, center.top, 1'b0} + {2'b00, right.top};
		sum_b = {2'b00, left.bot}  + {1'b0, center.bot, 1'b0} + {2'b00, right.bot};
		gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
		gy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});
	end

	assign px = gx_s2 * gx_s2;
	assign py = gy_s2 * gy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s2  <= gx;
			gy_s2  <= gy;
			sqx_s3 <= px[SQ_W-1:0];
			sqy_s3 <= py[SQ_W-1:0];
		end
	end

	assign mag2    = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign is_edge = {1'b0, mag2} > thr_sq;

endmodule
`default_nettype wire

### design/sobel_edge_threshold.sv
// Top level: streaming 3x3 Sobel edge detector with magnitude threshold.
//
//  channel | dir | handshake            | content
//  s_*     | in  | s_tvalid / s_tready  | RGB pixel, raster order
//  m_*     | out | m_tvalid / m_tready  | result pixel with coordinates, tlast
//  cfg_*   | in  | cfg_valid/cfg_ready  | register write, index + data
//
// One pixel per cycle while the output queue has room. A pixel reaches the output queue
// after acceptance through the line store read, gradient register and square register.
// s_tready drops while the 4-entry output queue holds more than two results, so a
// stalled m_tready holds the whole pipeline; pixels giving two results use two slots.
// The line stores are not cleared at reset; cfg_ready is always high.
`default_nettype none
module sobel_edge_threshold
	import sobel_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // pixel_red, pixel_green, pixel_blue
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata,  // out_column, out_row, out_red,
	                                             // out_green, out_blue, 1 bit zero pad
	output logic                       m_tlast,  // last_of_run
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;

	// configuration
	logic [CFG_W-1:0]    width_q, height_q;
	logic [THR_W-1:0]    thr_q;
	logic [THR_SQ_W-1:0] thr_sq_q;
	logic [CMPW-1:0]     width_ext, eff_width;
	logic [CW-1:0]       last_col;
	logic [ROW_W-1:0]    last_row;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(WIDTH_RESET);
			height_q <= CFG_W'(HEIGHT_RESET);
			thr_q    <= THR_W'(THR_RESET);
			thr_sq_q <= THR_SQ_W'(THR_RESET * THR_RESET);
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_IMAGE_WIDTH:  width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
					REG_EDGE_THRESH:  thr_q    <= cfg_data[THR_W-1:0];
					default:          ;
				endcase
			end
			thr_sq_q <= THR_SQ_W'(thr_q) * THR_SQ_W'(thr_q);
		end
	end

	always_comb begin
		width_ext = CMPW'(width_q);
		if (width_ext < CMPW'(MIN_DIM)) begin
			eff_width = CMPW'(MIN_DIM);
		end else if (width_ext > CMPW'(MAX_WIDTH)) begin
			eff_width = CMPW'(MAX_WIDTH);
		end else begin
			eff_width = width_ext;
		end
		last_col = CW'(eff_width - CMPW'(1));
		if (height_q < ROW_W'(MIN_DIM)) begin
			last_row = ROW_W'(MIN_DIM - 1);
		end else begin
			last_row = height_q - ROW_W'(1);
		end
	end

	// input side
	logic             adv, accept;
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [PIX_W-1:0] in_red, in_green, in_blue, bright;
	logic             in_interior, in_border;

	assign in_red   = s_tdata[PIX_W-1:0];
	assign in_green = s_tdata[2*PIX_W-1:PIX_W];
	assign in_blue  = s_tdata[3*PIX_W-1:2*PIX_W];

	always_comb begin
		bright = in_red;
		if (in_green > bright) begin
			bright = in_green;
		end
		if (in_blue > bright) begin
			bright = in_blue;
		end
	end

	// interior pixel (col-1,row-1) completes with this pixel; border pixel goes now
	assign in_interior = (col_q >= CW'(2)) && (row_q >= ROW_W'(2)) &&
	                     (col_q <= last_col) && (row_q <= last_row);
	assign in_border   = (row_q == '0) || (col_q == '0) ||
	                     (row_q >= last_row) || (col_q >= last_col);

	assign s_tready = adv;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q >= last_col) begin
				col_q <= '0;
				row_q <= (row_q >= last_row) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// pipeline stages 1..3
	logic             v_s1, v_s2, v_s3;
	logic [CW-1:0]    col_s1, col_s2, col_s3;
	logic [ROW_W-1:0] row_s1, row_s2, row_s3;
	logic [PIX_W-1:0] red_s1, red_s2, red_s3;
	logic [PIX_W-1:0] green_s1, green_s2, green_s3;
	logic [PIX_W-1:0] blue_s1, blue_s2, blue_s3;
	logic             int_s1, int_s2, int_s3;
	logic             brd_s1, brd_s2, brd_s3;
	logic [PIX_W-1:0] bright_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1    <= col_q;
			row_s1    <= row_q;
			red_s1    <= in_red;
			green_s1  <= in_green;
			blue_s1   <= in_blue;
			int_s1    <= in_interior;
			brd_s1    <= in_border;
			bright_s1 <= bright;
			col_s2    <= col_s1;
			row_s2    <= row_s1;
			red_s2    <= red_s1;
			green_s2  <= green_s1;
			blue_s2   <= blue_s1;
			int_s2    <= int_s1;
			brd_s2    <= brd_s1;
			col_s3    <= col_s2;
			row_s3    <= row_s2;
			red_s3    <= red_s2;
			green_s3  <= green_s2;
			blue_s3   <= blue_s2;
			int_s3    <= int_s2;
			brd_s3    <= brd_s2;
		end
	end

	// line stores: read at the column counter, written back one stage later
	logic             ls_we;
	logic [PIX_W-1:0] upper_rd, middle_rd;

	assign ls_we = adv && v_s1;

	sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
		.clk   (clk),
		.we    (ls_we),
		.waddr (col_s1),
		.wdata (middle_rd),
		.re    (adv),
		.raddr (col_q),
		.rdata (upper_rd)
	);

	sobel_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
		.clk   (clk),
		.we    (ls_we),
		.waddr (col_s1),
		.wdata (bright_s1),
		.re    (adv),
		.raddr (col_q),
		.rdata (middle_rd)
	);

	// window: win[0] is the new right column, then center, then left
	win_col_t win [WIN_CELLS+1];

	assign win[0] = '{top: upper_rd, mid: middle_rd, bot: bright_s1};

	for (genvar i = 0; i < WIN_CELLS; i++) begin : g_cell
		sobel_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ls_we),
			.din    (win[i]),
			.dout   (win[i+1])
		);
	end

	logic is_edge;

	sobel_mag u_mag (
		.clk     (clk),
		.en      (adv),
		.left    (win[2]),
		.center  (win[1]),
		.right   (win[0]),
		.thr_sq  (thr_sq_q),
		.is_edge (is_edge)
	);

	// result queue
	result_t                res_int, res_brd, entry0;
	logic                   push0, push1, pop;
	logic [PIX_W-1:0]       bin_val;
	result_t                fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]     wp_q, rp_q;
	logic [FIFO_CNT_W-1:0]  cnt_q;

	assign bin_val = is_edge ? PIX_BLACK : PIX_WHITE;

	always_comb begin
		res_int.col   = OUT_COL_W'(col_s3 - CW'(1));
		res_int.row   = row_s3 - ROW_W'(1);
		res_int.red   = bin_val;
		res_int.green = bin_val;
		res_int.blue  = bin_val;
		res_int.last  = !brd_s3;
		res_brd.col   = OUT_COL_W'(col_s3);
		res_brd.row   = row_s3;
		res_brd.red   = red_s3;
		res_brd.green = green_s3;
		res_brd.blue  = blue_s3;
		res_brd.last  = 1'b1;
		entry0        = int_s3 ? res_int : res_brd;
	end

	assign push0 = adv && v_s3 && (int_s3 || brd_s3);
	assign push1 = adv && v_s3 && int_s3 && brd_s3;
	assign pop   = m_tvalid && m_tready;
	assign adv   = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push0) begin
			fifo_q[wp_q] <= entry0;
		end
		if (push1) begin
			fifo_q[wp_q + FIFO_AW'(1)] <= res_brd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + FIFO_AW'(push0) + FIFO_AW'(push1);
			rp_q  <= rp_q + FIFO_AW'(pop);
			cnt_q <= cnt_q + FIFO_CNT_W'(push0) + FIFO_CNT_W'(push1) - FIFO_CNT_W'(pop);
		end
	end

	result_t head;

	assign head     = fifo_q[rp_q];
	assign m_tvalid = cnt_q != '0;
	assign m_tlast  = head.last;
	assign m_tdata  = {1'b0, head.blue, head.green, head.red, head.row, head.col};

	// queue never overfills
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
		else $error("result queue overflow");

	// line store write-back never hits the column being read
	a_ls_addr: assert property (@(posedge clk) disable iff (!arst_n)
		ls_we |-> (col_s1 != col_q))
		else $error("line store read/write address clash");

	// a pixel giving two results is only taken with two free queue slots
	a_two_push: assert property (@(posedge clk) disable iff (!arst_n)
		push1 |=> (cnt_q >= FIFO_CNT_W'(1)) && (cnt_q <= FIFO_CNT_W'(FIFO_DEPTH)))
		else $error("double push lost an entry");

endmodule
`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for sobel_edge_threshold: predicts each result from the pixel stream.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sobel_pkg::*;

	localparam int ROW_LSB     = OUT_COL_W;
	localparam int RED_LSB     = ROW_LSB + ROW_W;
	localparam int GRN_LSB     = RED_LSB + PIX_W;
	localparam int BLU_LSB     = GRN_LSB + PIX_W;
	localparam int PAD_BIT     = BLU_LSB + PIX_W;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int TARGET_PIX  = 1850;

	typedef enum int {
		PAT_NOISE,
		PAT_SMOOTH,
		PAT_SATURATED
	} pattern_t;

	// Tracks frame position, line stores and window; queues the pixels still to come out.
	class pixel_board;
		logic [PIX_W-1:0] upper_line [MAX_WIDTH_DEF];
		logic [PIX_W-1:0] middle_line [MAX_WIDTH_DEF];
		logic [PIX_W-1:0] win [6];
		int col;
		int row;
		logic [CFG_W-1:0] width_reg;
		logic [CFG_W-1:0] height_reg;
		logic [THR_W-1:0] thr_reg;
		result_t awaited_px [$];
		int fails;

		function new();
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			foreach (win[i]) win[i] = '0;
			col = 0;
			row = 0;
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			thr_reg = THR_RESET;
			fails = 0;
		endfunction

		function int eff_width();
			if (width_reg < MIN_DIM) return MIN_DIM;
			if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
			return width_reg;
		endfunction

		function int eff_height();
			if (height_reg < MIN_DIM) return MIN_DIM;
			return height_reg;
		endfunction

		function int awaited();
			return awaited_px.size();
		endfunction

		// pixels left until both counters return to zero
		function int pixels_to_frame_end();
			int w;
			int h;
			int n;
			w = eff_width();
			h = eff_height();
			n = (col >= w - 1) ? 1 : w - col;
			if (row < h - 1) n += (h - 1 - row) * w;
			return n;
		endfunction

		function void write_reg(logic [1:0] index, logic [CFG_W-1:0] data);
			case (cfg_reg_t'(index))
				REG_IMAGE_WIDTH: width_reg = data;
				REG_IMAGE_HEIGHT: height_reg = data;
				REG_EDGE_THRESH: thr_reg = data[THR_W-1:0];
				default: ;
			endcase
		endfunction

		function void take_pixel(logic [IN_DATA_W-1:0] data);
			logic [PIX_W-1:0] r, g, b, bright, top, mid, shade;
			int w, h, c, rw;
			int l0, l1, l2, c0, c2, t0, t1, t2, gx, gy, mag2, thr, thr2;
			result_t inner, outer;
			bit has_inner, has_outer;
			r = data[PIX_W-1:0];
			g = data[PIX_W +: PIX_W];
			b = data[2*PIX_W +: PIX_W];
			bright = r;
			if (g > bright) bright = g;
			if (b > bright) bright = b;
			w = eff_width();
			h = eff_height();
			c = col;
			rw = row;
			top = upper_line[c];
			mid = middle_line[c];
			upper_line[c] = mid;
			middle_line[c] = bright;

			has_inner = c >= 2 && rw >= 2 && c - 1 < w - 1 && rw - 1 < h - 1;
			has_outer = rw == 0 || c == 0 || rw >= h - 1 || c >= w - 1;
			if (has_inner) begin
				l0 = win[0];
				l1 = win[1];
				l2 = win[2];
				c0 = win[3];
				c2 = win[5];
				t0 = top;
				t1 = mid;
				t2 = bright;
				gx = (t0 + 2 * t1 + t2) - (l0 + 2 * l1 + l2);
				gy = (l2 + 2 * c2 + t2) - (l0 + 2 * c0 + t0);
				mag2 = gx * gx + gy * gy;
				thr = thr_reg;
				thr2 = thr * thr;
				shade = (mag2 > thr2) ? PIX_BLACK : PIX_WHITE;
				inner.col = c - 1;
				inner.row = rw - 1;
				inner.red = shade;
				inner.green = shade;
				inner.blue = shade;
				inner.last = !has_outer;
				awaited_px.push_back(inner);
			end
			if (has_outer) begin
				outer.col = c;
				outer.row = rw;
				outer.red = r;
				outer.green = g;
				outer.blue = b;
				outer.last = 1'b1;
				awaited_px.push_back(outer);
			end

			win[0] = win[3];
			win[1] = win[4];
			win[2] = win[5];
			win[3] = top;
			win[4] = mid;
			win[5] = bright;

			if (c >= w - 1) begin
				col = 0;
				row = (rw >= h - 1) ? 0 : rw + 1;
			end else begin
				col = c + 1;
			end
		endfunction

		function void compare(string name, int want, int got);
			if (want != got) begin
				if (fails < 100)
					$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
				fails++;
			end
		endfunction

		function void match_result(logic [OUT_DATA_W-1:0] data, logic last);
			result_t want;
			if (awaited_px.size() == 0) begin
				if (fails < 100)
					$display("%0t: result col %0d row %0d expected none, got one", $time,
						data[OUT_COL_W-1:0], data[ROW_LSB +: ROW_W]);
				fails++;
				return;
			end
			want = awaited_px.pop_front();
			compare("out_column", want.col, data[OUT_COL_W-1:0]);
			compare("out_row", want.row, data[ROW_LSB +: ROW_W]);
			compare("out_red", want.red, data[RED_LSB +: PIX_W]);
			compare("out_green", want.green, data[GRN_LSB +: PIX_W]);
			compare("out_blue", want.blue, data[BLU_LSB +: PIX_W]);
			compare("pad bit", 0, data[PAD_BIT]);
			compare("last_of_run", want.last, last);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;

	pixel_board board;
	bit steady = 1'b0;
	bit hold_flip = 1'b0;
	bit hold_seen = 1'b0;
	int hold_left = 0;
	int quiet = 0;
	int sent = 0;

	sobel_edge_threshold dut (
		.clk,
		.arst_n,
		.s_tvalid,
		.s_tready,
		.s_tdata,
		.m_tvalid,
		.m_tready,
		.m_tdata,
		.m_tlast,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side: random stalls, steady stretches, and a long hold-off on request
	always @(posedge clk) begin
		if (hold_flip != hold_seen) begin
			hold_seen <= hold_flip;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (steady) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 35);
		end
	end

	// results are checked before the pixel of the same edge is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
			if (m_tvalid && m_tready) board.match_result(m_tdata, m_tlast);
			if (s_tvalid && s_tready) board.take_pixel(s_tdata);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic put_reg(cfg_reg_t idx, int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
	endtask

	// a negative value leaves that register alone
	task automatic write_regs(int w, int h, int t);
		if (w >= 0) put_reg(REG_IMAGE_WIDTH, w);
		if (h >= 0) put_reg(REG_IMAGE_HEIGHT, h);
		if (t >= 0) put_reg(REG_EDGE_THRESH, t);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pixel(logic [IN_DATA_W-1:0] word);
		if (!steady) begin
			while ($urandom_range(99) < 35) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic send_run(int count, pattern_t pat, logic [PIX_W-1:0] base);
		logic [IN_DATA_W-1:0] word;
		int i;
		for (i = 0; i < count; i++) begin
			case (pat)
				PAT_NOISE: word = IN_DATA_W'($urandom);
				PAT_SMOOTH: word = {base ^ PIX_W'($urandom_range(7)),
					base ^ PIX_W'($urandom_range(7)), base ^ PIX_W'($urandom_range(7))};
				default: word = {$urandom_range(1) ? PIX_WHITE : PIX_BLACK,
					$urandom_range(1) ? PIX_WHITE : PIX_BLACK,
					$urandom_range(1) ? PIX_WHITE : PIX_BLACK};
			endcase
			send_pixel(word);
		end
	endtask

	// stop sending, wait for every pending result, then let the pipeline drain
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.awaited() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int w, h, t, n, frame;
		pattern_t pat;
		logic [PIX_W-1:0] base;
		logic [IN_DATA_W-1:0] corner_frame [9];
		board = new();
		// left column dark, right column bright: the lone interior pixel is an edge
		corner_frame = '{24'h000000, 24'h0000FF, 24'hFFFFFF,
			24'h000000, 24'h00FF00, 24'hFF0000,
			24'h000000, 24'hFF00FF, 24'hFFFFFF};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// both sizes below the minimum, zero threshold; last pixel gives two results
		write_regs(2, 0, 0);
		foreach (corner_frame[i]) send_pixel(corner_frame[i]);
		settle();

		// largest sizes and an over-range threshold, then shrink the width mid-row
		write_regs(12'hFFF, 12'hFFF, 12'hFFF);
		send_run(3, PAT_SATURATED, '0);
		settle();
		write_regs(3, -1, -1);
		send_run(7, PAT_SATURATED, '0);
		settle();
		write_regs(-1, 1, -1);
		send_run(board.pixels_to_frame_end(), PAT_NOISE, '0);

		frame = 0;
		while (sent < TARGET_PIX) begin
			settle();
			case ($urandom_range(7))
				0: w = $urandom_range(2);
				1: w = $urandom_range(40, 13);
				default: w = $urandom_range(12, 3);
			endcase
			case ($urandom_range(9))
				0: h = $urandom_range(2);
				1: h = $urandom_range(20, 9);
				default: h = $urandom_range(8, 3);
			endcase
			case ($urandom_range(5))
				0: t = 0;
				1: t = 1443;
				2: t = $urandom_range(4095);
				default: t = $urandom_range(400);
			endcase
			write_regs(w, h, t);
			steady <= (frame >= 8 && frame < 14);
			if (frame == 4 || frame == 11) hold_flip <= ~hold_flip;
			pat = pattern_t'($urandom_range(2));
			base = $urandom_range(255);
			n = board.pixels_to_frame_end();
			if ($urandom_range(3) == 0) begin
				// size change mid-frame; the width only shrinks so no stale line entry is read
				send_run($urandom_range(n - 1, 1), pat, base);
				settle();
				if ($urandom_range(1))
					write_regs($urandom_range(board.eff_width(), 3), -1, -1);
				else
					write_regs(-1, $urandom_range(10), -1);
				n = board.pixels_to_frame_end();
			end
			send_run(n, pat, base);
			frame++;
		end
		settle();

		if (board.fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

### files.f
design/sobel_pkg.sv
design/sobel_ram.sv
design/sobel_cell.sv
design/sobel_mag.sv
design/sobel_edge_threshold.sv
dv/testbench.sv
